### design/skm_pkg.sv
package skm_pkg;

    localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_SINGULAR = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    // Quotient bits kept by the divider; anything larger is saturated.
    localparam int DIV_QBITS   = 33;
    localparam int DIV_LAT     = DIV_QBITS + 2;
    localparam int FRONT_LAT   = 3;
    localparam int BACK_LAT    = 5;
    localparam int LATENCY     = FRONT_LAT + DIV_LAT + BACK_LAT;

    typedef struct packed {
        logic signed [31:0] lam_first;
        logic signed [31:0] lam_second;
        logic signed [31:0] grad_first;
        logic signed [31:0] grad_second;
        logic signed [31:0] hess_aa;
        logic signed [31:0] hess_ab;
        logic signed [31:0] hess_bb;
    } t_in;

    typedef struct packed {
        logic signed [31:0] mult_first;
        logic signed [31:0] mult_second;
        logic        [1:0]  active_count;
        logic        [1:0]  status;
    } t_out;

    // Saturated fixed-point value with its overflow flag.
    typedef struct packed {
        logic               ovf;
        logic signed [31:0] v;
    } t_fr;

    // Everything the back end needs, plus the divider operands.
    typedef struct packed {
        logic               a0;
        logic               a1;
        logic               a2;
        logic               sing;
        logic               fl0;
        logic               fl1;
        logic               fl2;
        logic               flv;
        logic               fl_a;
        logic               fl_b;
        logic signed [31:0] g0;
        logic signed [31:0] g1;
        logic signed [31:0] aa;
        logic signed [31:0] bb;
        logic signed [31:0] dif_a;
        logic signed [31:0] dif_b;
        logic signed [31:0] c;
        logic signed [31:0] mabg1;
        logic signed [31:0] mabg0;
        logic signed [31:0] num;
        logic signed [31:0] den_ab;
        logic signed [31:0] negab;
        logic signed [31:0] det;
    } t_mid;

    function automatic t_fr f_sat(input logic signed [63:0] x);
        t_fr r;
        if (x > 64'sd2147483647) begin
            r.ovf = 1'b1;
            r.v   = S32_MAX;
        end else if (x < -64'sd2147483648) begin
            r.ovf = 1'b1;
            r.v   = S32_MIN;
        end else begin
            r.ovf = 1'b0;
            r.v   = x[31:0];
        end
        return r;
    endfunction

    function automatic t_fr f_add(input logic signed [31:0] a, input logic signed [31:0] b);
        return f_sat(64'(a) + 64'(b));
    endfunction

    function automatic t_fr f_sub(input logic signed [31:0] a, input logic signed [31:0] b);
        return f_sat(64'(a) - 64'(b));
    endfunction

    function automatic t_fr f_neg(input logic signed [31:0] a);
        return f_sat(-64'(a));
    endfunction

    // Product scaled down by 2^frac, truncated toward zero.
    function automatic t_fr f_mul(input logic signed [31:0] a, input logic signed [31:0] b,
                                  input int frac);
        logic signed [63:0] p;
        logic signed [63:0] q;
        logic signed [63:0] m;
        p = 64'(a) * 64'(b);
        q = p >>> frac;
        m = (64'sd1 <<< frac) - 64'sd1;
        if (p < 0 && (p & m) != 64'sd0) begin
            q = q + 64'sd1;
        end
        return f_sat(q);
    endfunction

    function automatic logic [32:0] f_mag33(input logic signed [31:0] a);
        logic signed [32:0] w;
        w = 33'(a);
        return w[32] ? 33'(-w) : 33'(w);
    endfunction

endpackage

### design/simplex_kkt_multipliers.sv
// KKT multipliers of a point on the 2-simplex.
//
// Input: pulse i_start with i_item (point, gradient, Hessian, all signed
// fixed point with FRAC_BITS fraction bits); the item is taken at a clock edge
// where i_start is high and o_busy is low. o_busy is high only during reset,
// so one item can be started every cycle.
// Output: o_valid marks o_result for exactly one cycle, after the item has
// passed the front-end arithmetic, the divider pipeline of one quotient bit
// per stage and the back end. One result per item, in order; the receiver
// cannot stall, so no backpressure exists anywhere.
// Configuration: the tolerance is written through i_cfg_valid/o_cfg_ready
// (ready is always high); write it only while no item is in flight.
// Reset (synchronous, active low) drops all items in flight and sets the
// tolerance to 1.
module simplex_kkt_multipliers
    import skm_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  t_in         i_item,
    output logic        o_valid,
    output t_out        o_result,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    logic [15:0]        r_tol;
    logic               w_acc;
    logic               w_fvld;
    t_mid               w_mid;
    logic [DIV_LAT-1:0] r_dvld;
    t_mid               r_dmid [0:DIV_LAT-1];
    t_fr                w_q1, w_q2, w_q3, w_q4, w_q5, w_q6;

    assign o_busy      = ~i_rst_n;
    assign o_cfg_ready = 1'b1;
    assign w_acc       = i_start & ~o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= 16'd1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_tol <= i_cfg_data;
        end
    end

    skm_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_acc),
        .i_item  (i_item),
        .i_tol   (r_tol),
        .o_vld   (w_fvld),
        .o_mid   (w_mid)
    );

    skm_div #(.FRAC_BITS(FRAC_BITS)) u_div1 (
        .i_clk (i_clk), .i_num (w_mid.mabg1), .i_den (w_mid.bb), .o_quo (w_q1)
    );
    skm_div #(.FRAC_BITS(FRAC_BITS)) u_div2 (
        .i_clk (i_clk), .i_num (w_mid.mabg0), .i_den (w_mid.aa), .o_quo (w_q2)
    );
    skm_div #(.FRAC_BITS(FRAC_BITS)) u_div3 (
        .i_clk (i_clk), .i_num (w_mid.num), .i_den (w_mid.den_ab), .o_quo (w_q3)
    );
    skm_div #(.FRAC_BITS(FRAC_BITS)) u_div4 (
        .i_clk (i_clk), .i_num (w_mid.bb), .i_den (w_mid.det), .o_quo (w_q4)
    );
    skm_div #(.FRAC_BITS(FRAC_BITS)) u_div5 (
        .i_clk (i_clk), .i_num (w_mid.negab), .i_den (w_mid.det), .o_quo (w_q5)
    );
    skm_div #(.FRAC_BITS(FRAC_BITS)) u_div6 (
        .i_clk (i_clk), .i_num (w_mid.aa), .i_den (w_mid.det), .o_quo (w_q6)
    );

    // Carry the item alongside the dividers so both arrive together.
    always_ff @(posedge i_clk) begin
        r_dmid[0] <= w_mid;
        for (int j = 1; j < DIV_LAT; j++) begin
            r_dmid[j] <= r_dmid[j-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dvld <= '0;
        end else begin
            r_dvld <= {r_dvld[DIV_LAT-2:0], w_fvld};
        end
    end

    skm_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (r_dvld[DIV_LAT-1]),
        .i_mid    (r_dmid[DIV_LAT-1]),
        .i_q1     (w_q1),
        .i_q2     (w_q2),
        .i_q3     (w_q3),
        .i_q4     (w_q4),
        .i_q5     (w_q5),
        .i_q6     (w_q6),
        .o_vld    (o_valid),
        .o_result (o_result)
    );

endmodule

### design/skm_div.sv
module skm_div
    import skm_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic signed [31:0] i_num,
    input  logic signed [31:0] i_den,
    output t_fr                o_quo
);

    localparam int NW = 32 + FRAC_BITS;
    localparam int QB = DIV_QBITS;

    typedef struct packed {
        logic [31:0]   rem;
        logic [QB-1:0] low;
        logic [QB-1:0] quo;
        logic [31:0]   den;
        logic          neg;
        logic          zero;
        logic          big;
        logic          num_neg;
    } t_dst;

    t_dst        r_st [0:QB];
    logic [31:0] w_nmag;
    logic [31:0] w_dmag;
    logic [NW-1:0] w_nfull;
    t_fr         n_quo;
    t_fr         r_quo;

    always_comb begin
        w_nmag  = i_num[31] ? 32'(~i_num + 32'sd1) : 32'(i_num);
        w_dmag  = i_den[31] ? 32'(~i_den + 32'sd1) : 32'(i_den);
        w_nfull = {w_nmag, {FRAC_BITS{1'b0}}};
    end

    // Top bits seed the remainder; if they already reach the divisor the
    // quotient cannot fit and the result saturates.
    always_ff @(posedge i_clk) begin
        r_st[0].rem     <= 32'(w_nfull[NW-1:QB]);
        r_st[0].low     <= w_nfull[QB-1:0];
        r_st[0].quo     <= '0;
        r_st[0].den     <= w_dmag;
        r_st[0].neg     <= i_num[31] ^ i_den[31];
        r_st[0].zero    <= (i_den == 32'sd0);
        r_st[0].big     <= (32'(w_nfull[NW-1:QB]) >= w_dmag);
        r_st[0].num_neg <= i_num[31];
    end

    genvar k;
    generate
        for (k = 1; k <= QB; k++) begin : g_step
            logic [32:0] w_t;
            logic [32:0] w_s;
            logic        w_ge;
            t_dst        n_st;
            always_comb begin
                w_t      = {r_st[k-1].rem, r_st[k-1].low[QB-1]};
                w_s      = w_t - {1'b0, r_st[k-1].den};
                w_ge     = (w_t >= {1'b0, r_st[k-1].den});
                n_st     = r_st[k-1];
                n_st.rem = w_ge ? w_s[31:0] : w_t[31:0];
                n_st.low = {r_st[k-1].low[QB-2:0], 1'b0};
                n_st.quo = {r_st[k-1].quo[QB-2:0], w_ge};
            end
            always_ff @(posedge i_clk) begin
                r_st[k] <= n_st;
            end
        end
    endgenerate

    always_comb begin
        n_quo.ovf = 1'b0;
        n_quo.v   = '0;
        if (r_st[QB].zero) begin
            n_quo.ovf = 1'b1;
            n_quo.v   = r_st[QB].num_neg ? S32_MIN : S32_MAX;
        end else if (r_st[QB].big) begin
            n_quo.ovf = 1'b1;
            n_quo.v   = r_st[QB].neg ? S32_MIN : S32_MAX;
        end else if (!r_st[QB].neg) begin
            if (r_st[QB].quo > 33'h0_7fff_ffff) begin
                n_quo.ovf = 1'b1;
                n_quo.v   = S32_MAX;
            end else begin
                n_quo.v   = r_st[QB].quo[31:0];
            end
        end else begin
            if (r_st[QB].quo > 33'h0_8000_0000) begin
                n_quo.ovf = 1'b1;
                n_quo.v   = S32_MIN;
            end else begin
                n_quo.v   = 32'(~r_st[QB].quo[31:0] + 32'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
    end

    assign o_quo = r_quo;

endmodule

### design/skm_front.sv
module skm_front
    import skm_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_vld,
    input  t_in         i_item,
    input  logic [15:0] i_tol,
    output logic        o_vld,
    output t_mid        o_mid
);

    typedef struct packed {
        logic               a0;
        logic               a1;
        logic               a2;
        logic signed [31:0] g0;
        logic signed [31:0] g1;
        logic signed [31:0] aa;
        logic signed [31:0] bb;
        t_fr                mabg1;
        t_fr                mabg0;
        t_fr                maabb;
        t_fr                mabab;
        t_fr                dif_a;
        t_fr                dif_b;
        t_fr                negab;
        t_fr                aabb;
        t_fr                abab;
    } t_f1;

    typedef struct packed {
        logic               a0;
        logic               a1;
        logic               a2;
        logic signed [31:0] g0;
        logic signed [31:0] g1;
        logic signed [31:0] aa;
        logic signed [31:0] bb;
        t_fr                mabg1;
        t_fr                mabg0;
        t_fr                dif_a;
        t_fr                dif_b;
        t_fr                negab;
        t_fr                mag0;
        t_fr                mbg1;
        t_fr                den_ab;
        t_fr                det;
        t_fr                c;
    } t_f2;

    t_f1  n_s1, r_s1;
    t_f2  n_s2, r_s2;
    t_mid n_mid, r_mid;
    logic [2:0] r_vld;

    logic signed [33:0] w_rest;
    logic [33:0]        w_rest_mag;
    t_fr                w_det;
    t_fr                w_c;
    t_fr                w_num;

    always_comb begin
        w_rest     = (34'sd1 <<< FRAC_BITS) - 34'(i_item.lam_first) - 34'(i_item.lam_second);
        w_rest_mag = w_rest[33] ? 34'(-w_rest) : 34'(w_rest);

        n_s1.a0    = f_mag33(i_item.lam_first) < 33'(i_tol);
        n_s1.a1    = f_mag33(i_item.lam_second) < 33'(i_tol);
        n_s1.a2    = w_rest_mag < 34'(i_tol);
        n_s1.g0    = i_item.grad_first;
        n_s1.g1    = i_item.grad_second;
        n_s1.aa    = i_item.hess_aa;
        n_s1.bb    = i_item.hess_bb;
        n_s1.mabg1 = f_mul(i_item.hess_ab, i_item.grad_second, FRAC_BITS);
        n_s1.mabg0 = f_mul(i_item.hess_ab, i_item.grad_first, FRAC_BITS);
        n_s1.maabb = f_mul(i_item.hess_aa, i_item.hess_bb, FRAC_BITS);
        n_s1.mabab = f_mul(i_item.hess_ab, i_item.hess_ab, FRAC_BITS);
        n_s1.dif_a = f_sub(i_item.hess_bb, i_item.hess_ab);
        n_s1.dif_b = f_sub(i_item.hess_aa, i_item.hess_ab);
        n_s1.negab = f_neg(i_item.hess_ab);
        n_s1.aabb  = f_add(i_item.hess_aa, i_item.hess_bb);
        n_s1.abab  = f_add(i_item.hess_ab, i_item.hess_ab);
    end

    always_comb begin
        n_s2.a0     = r_s1.a0;
        n_s2.a1     = r_s1.a1;
        n_s2.a2     = r_s1.a2;
        n_s2.g0     = r_s1.g0;
        n_s2.g1     = r_s1.g1;
        n_s2.aa     = r_s1.aa;
        n_s2.bb     = r_s1.bb;
        n_s2.mabg1  = r_s1.mabg1;
        n_s2.mabg0  = r_s1.mabg0;
        n_s2.dif_a  = r_s1.dif_a;
        n_s2.dif_b  = r_s1.dif_b;
        n_s2.negab  = r_s1.negab;
        n_s2.mag0   = f_mul(r_s1.dif_a.v, r_s1.g0, FRAC_BITS);
        n_s2.mbg1   = f_mul(r_s1.dif_b.v, r_s1.g1, FRAC_BITS);
        n_s2.den_ab = f_add(r_s1.dif_a.v, r_s1.dif_b.v);
        // Fold the flags of the operands into det and c.
        w_det       = f_sub(r_s1.maabb.v, r_s1.mabab.v);
        w_c         = f_sub(r_s1.aabb.v, r_s1.abab.v);
        n_s2.det.v   = w_det.v;
        n_s2.det.ovf = w_det.ovf | r_s1.maabb.ovf | r_s1.mabab.ovf;
        n_s2.c.v     = w_c.v;
        n_s2.c.ovf   = w_c.ovf | r_s1.aabb.ovf | r_s1.abab.ovf;
    end

    always_comb begin
        w_num        = f_add(r_s2.mag0.v, r_s2.mbg1.v);
        n_mid.a0     = r_s2.a0;
        n_mid.a1     = r_s2.a1;
        n_mid.a2     = r_s2.a2;
        n_mid.sing   = f_mag33(r_s2.det.v) < 33'(i_tol);
        n_mid.fl0    = r_s2.mabg1.ovf;
        n_mid.fl1    = r_s2.mabg0.ovf;
        n_mid.fl2    = r_s2.dif_a.ovf | r_s2.dif_b.ovf | r_s2.mag0.ovf | r_s2.mbg1.ovf
                     | r_s2.den_ab.ovf | w_num.ovf;
        n_mid.flv    = r_s2.det.ovf | r_s2.negab.ovf | r_s2.c.ovf;
        n_mid.fl_a   = r_s2.dif_a.ovf;
        n_mid.fl_b   = r_s2.dif_b.ovf;
        n_mid.g0     = r_s2.g0;
        n_mid.g1     = r_s2.g1;
        n_mid.aa     = r_s2.aa;
        n_mid.bb     = r_s2.bb;
        n_mid.dif_a  = r_s2.dif_a.v;
        n_mid.dif_b  = r_s2.dif_b.v;
        n_mid.c      = r_s2.c.v;
        n_mid.mabg1  = r_s2.mabg1.v;
        n_mid.mabg0  = r_s2.mabg0.v;
        n_mid.num    = w_num.v;
        n_mid.den_ab = r_s2.den_ab.v;
        n_mid.negab  = r_s2.negab.v;
        n_mid.det    = r_s2.det.v;
    end

    always_ff @(posedge i_clk) begin
        r_s1  <= n_s1;
        r_s2  <= n_s2;
        r_mid <= n_mid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_vld};
        end
    end

    assign o_vld = r_vld[2];
    assign o_mid = r_mid;

endmodule

### design/skm_back.sv
module skm_back
    import skm_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_vld,
    input  t_mid i_mid,
    input  t_fr  i_q1,
    input  t_fr  i_q2,
    input  t_fr  i_q3,
    input  t_fr  i_q4,
    input  t_fr  i_q5,
    input  t_fr  i_q6,
    output logic o_vld,
    output t_out o_result
);

    typedef struct packed {
        logic               a0;
        logic               a1;
        logic               a2;
        logic               sing;
        logic               fl0;
        logic               fl1;
        logic               fl2;
        logic               flv;
        logic signed [31:0] g0;
        logic signed [31:0] g1;
        logic signed [31:0] m0a;
        logic signed [31:0] m0b;
        logic signed [31:0] m0c;
    } t_bc;

    typedef struct packed {
        t_bc                bc;
        logic               fl_a;
        logic               fl_b;
        logic signed [31:0] aa;
        logic signed [31:0] bb;
        logic signed [31:0] dif_a;
        logic signed [31:0] dif_b;
        logic signed [31:0] c;
        logic signed [31:0] t0;
        logic signed [31:0] t1;
        logic signed [31:0] t2;
        logic signed [31:0] t3;
    } t_b1;

    typedef struct packed {
        t_bc                bc;
        logic               fl_a;
        logic               fl_b;
        logic signed [31:0] aa;
        logic signed [31:0] bb;
        logic signed [31:0] dif_a;
        logic signed [31:0] dif_b;
        logic signed [31:0] c;
        logic signed [31:0] p0;
        logic signed [31:0] p1;
    } t_b2;

    typedef struct packed {
        t_bc                bc;
        logic signed [31:0] c;
        logic signed [31:0] s;
        logic signed [31:0] p;
        logic signed [31:0] d;
        logic signed [31:0] e;
    } t_b3;

    typedef struct packed {
        t_bc                bc;
        logic signed [31:0] u0;
        logic signed [31:0] u1;
        logic signed [31:0] u2;
        logic signed [31:0] u3;
    } t_b4;

    t_b1  n_b1, r_b1;
    t_b2  n_b2, r_b2;
    t_b3  n_b3, r_b3;
    t_b4  n_b4, r_b4;
    t_out n_res, r_res;
    logic [4:0] r_vld;

    t_fr w_sa, w_sb, w_nc, w_t0, w_t1, w_t2, w_t3;
    t_fr w_p0, w_p1, w_s;
    t_fr w_u0, w_u1, w_u2, w_u3;
    t_fr w_v0, w_v1;
    logic [1:0] w_k;
    logic       w_fl;

    always_comb begin
        w_sa = f_sub(i_mid.g0, i_q1.v);
        w_sb = f_sub(i_mid.g1, i_q2.v);
        w_nc = f_neg(i_q3.v);
        w_t0 = f_mul(i_q4.v, i_mid.g0, FRAC_BITS);
        w_t1 = f_mul(i_q5.v, i_mid.g1, FRAC_BITS);
        w_t2 = f_mul(i_q5.v, i_mid.g0, FRAC_BITS);
        w_t3 = f_mul(i_q6.v, i_mid.g1, FRAC_BITS);

        n_b1.bc.a0   = i_mid.a0;
        n_b1.bc.a1   = i_mid.a1;
        n_b1.bc.a2   = i_mid.a2;
        n_b1.bc.sing = i_mid.sing;
        n_b1.bc.fl0  = i_mid.fl0 | i_q1.ovf | w_sa.ovf;
        n_b1.bc.fl1  = i_mid.fl1 | i_q2.ovf | w_sb.ovf;
        n_b1.bc.fl2  = i_mid.fl2 | i_q3.ovf | w_nc.ovf;
        n_b1.bc.flv  = i_mid.flv | i_q4.ovf | i_q5.ovf | i_q6.ovf
                     | w_t0.ovf | w_t1.ovf | w_t2.ovf | w_t3.ovf;
        n_b1.bc.g0   = i_mid.g0;
        n_b1.bc.g1   = i_mid.g1;
        n_b1.bc.m0a  = w_sa.v;
        n_b1.bc.m0b  = w_sb.v;
        n_b1.bc.m0c  = w_nc.v;
        n_b1.fl_a    = i_mid.fl_a;
        n_b1.fl_b    = i_mid.fl_b;
        n_b1.aa      = i_mid.aa;
        n_b1.bb      = i_mid.bb;
        n_b1.dif_a   = i_mid.dif_a;
        n_b1.dif_b   = i_mid.dif_b;
        n_b1.c       = i_mid.c;
        n_b1.t0      = w_t0.v;
        n_b1.t1      = w_t1.v;
        n_b1.t2      = w_t2.v;
        n_b1.t3      = w_t3.v;
    end

    always_comb begin
        w_p0         = f_add(r_b1.t0, r_b1.t1);
        w_p1         = f_add(r_b1.t2, r_b1.t3);
        n_b2.bc      = r_b1.bc;
        n_b2.bc.flv  = r_b1.bc.flv | w_p0.ovf | w_p1.ovf;
        n_b2.fl_a    = r_b1.fl_a;
        n_b2.fl_b    = r_b1.fl_b;
        n_b2.aa      = r_b1.aa;
        n_b2.bb      = r_b1.bb;
        n_b2.dif_a   = r_b1.dif_a;
        n_b2.dif_b   = r_b1.dif_b;
        n_b2.c       = r_b1.c;
        n_b2.p0      = w_p0.v;
        n_b2.p1      = w_p1.v;
    end

    // The vertex with the first constraint uses p0, dif_a and bb, otherwise p1, dif_b and aa.
    always_comb begin
        w_s          = f_add(r_b2.p0, r_b2.p1);
        n_b3.bc      = r_b2.bc;
        n_b3.bc.flv  = r_b2.bc.flv | w_s.ovf | (r_b2.bc.a0 ? r_b2.fl_a : r_b2.fl_b);
        n_b3.c       = r_b2.c;
        n_b3.s       = w_s.v;
        n_b3.p       = r_b2.bc.a0 ? r_b2.p0 : r_b2.p1;
        n_b3.d       = r_b2.bc.a0 ? r_b2.dif_a : r_b2.dif_b;
        n_b3.e       = r_b2.bc.a0 ? r_b2.bb : r_b2.aa;
    end

    always_comb begin
        w_u0         = f_mul(r_b3.c, r_b3.p, FRAC_BITS);
        w_u1         = f_mul(r_b3.d, r_b3.s, FRAC_BITS);
        w_u2         = f_mul(r_b3.d, r_b3.p, FRAC_BITS);
        w_u3         = f_mul(r_b3.e, r_b3.s, FRAC_BITS);
        n_b4.bc      = r_b3.bc;
        n_b4.bc.flv  = r_b3.bc.flv | w_u0.ovf | w_u1.ovf | w_u2.ovf | w_u3.ovf;
        n_b4.u0      = w_u0.v;
        n_b4.u1      = w_u1.v;
        n_b4.u2      = w_u2.v;
        n_b4.u3      = w_u3.v;
    end

    always_comb begin
        w_v0 = f_sub(r_b4.u0, r_b4.u1);
        w_v1 = f_sub(r_b4.u2, r_b4.u3);
        w_k  = 2'({1'b0, r_b4.bc.a0}) + 2'({1'b0, r_b4.bc.a1}) + 2'({1'b0, r_b4.bc.a2});
        w_fl = 1'b0;
        n_res.mult_first   = '0;
        n_res.mult_second  = '0;
        n_res.active_count = w_k;
        n_res.status       = ST_OK;
        if (w_k == 2'd0 || w_k == 2'd3) begin
            n_res.status = ST_INVALID;
        end else if (w_k == 2'd1) begin
            if (r_b4.bc.a0) begin
                n_res.mult_first = r_b4.bc.m0a;
                w_fl             = r_b4.bc.fl0;
            end else if (r_b4.bc.a1) begin
                n_res.mult_first = r_b4.bc.m0b;
                w_fl             = r_b4.bc.fl1;
            end else begin
                n_res.mult_first = r_b4.bc.m0c;
                w_fl             = r_b4.bc.fl2;
            end
            n_res.status = w_fl ? ST_OVERFLOW : ST_OK;
        end else if (r_b4.bc.a0 && r_b4.bc.a1) begin
            n_res.mult_first  = r_b4.bc.g0;
            n_res.mult_second = r_b4.bc.g1;
        end else if (r_b4.bc.sing) begin
            n_res.status = ST_SINGULAR;
        end else begin
            n_res.mult_first  = w_v0.v;
            n_res.mult_second = w_v1.v;
            w_fl              = r_b4.bc.flv | w_v0.ovf | w_v1.ovf;
            n_res.status      = w_fl ? ST_OVERFLOW : ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b1  <= n_b1;
        r_b2  <= n_b2;
        r_b3  <= n_b3;
        r_b4  <= n_b4;
        r_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[3:0], i_vld};
        end
    end

    assign o_vld    = r_vld[4];
    assign o_result = r_res;

endmodule

### design/skm_chk.sv
module skm_chk
    import skm_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_start,
    input logic        o_busy,
    input t_in         i_item,
    input logic        o_valid,
    input t_out        o_result,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic [15:0] i_cfg_data
);

    // Every started beat comes back as a result beat.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##LATENCY o_valid)
        else $error("result beat missing after start");

    // No result beat without a matching start.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start && !o_busy, LATENCY))
        else $error("result beat without start");

    a_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status == ST_INVALID) |->
        (o_result.mult_first == 32'sd0 && o_result.mult_second == 32'sd0
         && (o_result.active_count == 2'd0 || o_result.active_count == 2'd3)))
        else $error("invalid active set with nonzero multipliers");

    a_face: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.active_count == 2'd1) |-> o_result.mult_second == 32'sd0)
        else $error("second multiplier set on a single face");

    a_singular: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status == ST_SINGULAR) |->
        (o_result.active_count == 2'd2 && o_result.mult_first == 32'sd0
         && o_result.mult_second == 32'sd0))
        else $error("singular status outside a vertex");

endmodule

bind simplex_kkt_multipliers skm_chk u_skm_chk (.*);
